// ===== rtl/b64lw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, constants and the base64 symbol table for the line-wrapping
// base64 encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

    localparam logic [7:0] WRAP_RESET        = 8'd72;
    localparam int         JOB_DEPTH_DEFAULT = 2;

    localparam logic [7:0] CHAR_PAD     = 8'h3D;   // '='
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;   // '\n'

    // One request from front to back: four characters, then an optional newline.
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic            nl;
        logic            last;
    } t_job;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] sym(input logic [5:0] v);
        logic [7:0] v8;
        v8 = {2'b00, v};
        if (v < 6'd26) begin
            return 8'd65 + v8;
        end else if (v < 6'd52) begin
            return 8'd71 + v8;              // 'a' - 26
        end else if (v < 6'd62) begin
            return v8 - 8'd4;               // '0' - 52
        end else if (v == 6'd62) begin
            return 8'h2B;                   // '+'
        end else begin
            return 8'h2F;                   // '/'
        end
    endfunction

endpackage

// ===== rtl/b64lw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_front
// Byte intake: gathers groups of three, tracks line length and wrap, and
// hands finished groups to the job queue as character requests.
// ----------------------------------------------------------------------------
module b64lw_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [7:0]       i_data_byte,
    input  logic             i_final_byte,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_q_full,
    output logic             o_q_push,
    output b64lw_pkg::t_job  o_q_job
);

    logic [7:0]  r_wrap, n_wrap;
    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_held, n_held;
    logic [7:0]  r_len, n_len;

    logic        accept;
    logic [1:0]  phase;
    logic [7:0]  b0, b1, b;
    logic [8:0]  len_sum;
    logic [7:0]  len_sat;
    logic        wrap_hit;

    assign o_full = i_q_full;
    assign accept = i_push && !i_q_full;
    assign phase  = (r_phase == 2'd3) ? 2'd0 : r_phase;
    assign b0     = r_held[15:8];
    assign b1     = r_held[7:0];
    assign b      = i_data_byte;

    assign len_sum  = {1'b0, r_len} + 9'd4;
    assign len_sat  = len_sum[8] ? 8'hFF : len_sum[7:0];
    assign wrap_hit = (len_sat >= r_wrap);

    always_comb begin
        n_wrap  = i_cfg_we ? i_cfg_wdata : r_wrap;
        n_phase = r_phase;
        n_held  = r_held;
        n_len   = r_len;
        o_q_push = 1'b0;
        o_q_job  = '0;
        if (accept) begin
            if (phase == 2'd2) begin
                o_q_push      = 1'b1;
                o_q_job.chars[0] = b64lw_pkg::sym(b0[7:2]);
                o_q_job.chars[1] = b64lw_pkg::sym({b0[1:0], b1[7:4]});
                o_q_job.chars[2] = b64lw_pkg::sym({b1[3:0], b[7:6]});
                o_q_job.chars[3] = b64lw_pkg::sym(b[5:0]);
                o_q_job.nl    = wrap_hit || i_final_byte;
                o_q_job.last  = i_final_byte;
                n_phase       = 2'd0;
                n_len         = (wrap_hit || i_final_byte) ? 8'd0 : len_sat;
            end else if (!i_final_byte) begin
                if (phase == 2'd0) begin
                    n_held = {b, 8'd0};
                end else begin
                    n_held = {b0, b};
                end
                n_phase = phase + 2'd1;
            end else begin
                // short final group, padded to four
                o_q_push = 1'b1;
                if (phase == 2'd0) begin
                    o_q_job.chars[0] = b64lw_pkg::sym(b[7:2]);
                    o_q_job.chars[1] = b64lw_pkg::sym({b[1:0], 4'd0});
                    o_q_job.chars[2] = b64lw_pkg::CHAR_PAD;
                end else begin
                    o_q_job.chars[0] = b64lw_pkg::sym(b0[7:2]);
                    o_q_job.chars[1] = b64lw_pkg::sym({b0[1:0], b[7:4]});
                    o_q_job.chars[2] = b64lw_pkg::sym({b[3:0], 2'd0});
                end
                o_q_job.chars[3] = b64lw_pkg::CHAR_PAD;
                o_q_job.nl    = 1'b1;
                o_q_job.last  = 1'b1;
                n_phase       = 2'd0;
                n_len         = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap  <= b64lw_pkg::WRAP_RESET;
            r_phase <= 2'd0;
            r_len   <= 8'd0;
        end else begin
            r_wrap  <= n_wrap;
            r_phase <= n_phase;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("group phase reached unused code");
    a_final_resets_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_final_byte) |=> (r_len == 8'd0 && r_phase == 2'd0))
        else $error("final byte did not clear line state");
`endif

endmodule

// ===== rtl/b64lw_jobq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_jobq
// Small register queue of character requests between intake and output.
// ----------------------------------------------------------------------------
module b64lw_jobq #(
    parameter int DEPTH = b64lw_pkg::JOB_DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64lw_pkg::t_job  i_job,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output b64lw_pkg::t_job  o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64lw_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request pushed into full queue");
`endif

endmodule

// ===== rtl/b64lw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_back
// Character output: walks one request a character per cycle, while the
// output register is empty or being popped, into a registered output stage.
// ----------------------------------------------------------------------------
module b64lw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  b64lw_pkg::t_job  i_q_job,
    output logic             o_q_pop,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [7:0]       o_out_char,
    output logic             o_last_char
);

    b64lw_pkg::t_job r_cur;
    logic            r_cur_valid;
    logic [2:0]      r_pos;
    logic            r_out_valid;
    logic [7:0]      r_out_char;
    logic            r_out_last;

    logic            out_take;
    logic            step;
    logic            at_end;
    logic [7:0]      cur_char;

    assign out_take = !r_out_valid || i_pop;
    assign step     = r_cur_valid && out_take;
    assign at_end   = r_cur.nl ? (r_pos == 3'd4) : (r_pos == 3'd3);
    assign cur_char = (r_pos == 3'd4) ? b64lw_pkg::CHAR_NEWLINE : r_cur.chars[r_pos[1:0]];
    assign o_q_pop  = i_q_valid && (!r_cur_valid || (step && at_end));

    assign o_empty     = !r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_pos       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_cur_valid <= 1'b1;
                r_pos       <= 3'd0;
            end else if (step) begin
                if (at_end) begin
                    r_cur_valid <= 1'b0;
                end
                r_pos <= r_pos + 3'd1;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_job;
        end
        if (step) begin
            r_out_char <= cur_char;
            r_out_last <= r_cur.last && at_end;
        end
    end

`ifndef SYNTHESIS
    a_last_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_char == b64lw_pkg::CHAR_NEWLINE))
        else $error("last character is not a newline");
    a_pos_needs_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_valid && r_pos == 3'd4) |-> r_cur.nl)
        else $error("newline slot walked without newline request");
`endif

endmodule

// ===== rtl/base64_encoder_line_wrap.sv =====
`timescale 1ns / 1ps
// Streaming base64 encoder (standard alphabet) with line wrapping. Bytes go in
// through a push/full queue port, one per cycle while full is low; characters
// come out through an empty/pop port, one per cycle while requests are queued
// and the consumer pops. Every third byte makes four characters plus a newline
// when the line reaches wrap_chars; the final byte closes the message, with
// '=' padding if its group is short, and a newline that carries o_last_char.
// The output side is the limit: one character leaves per cycle. Bytes that
// complete no group make no request and are taken whenever the request queue
// has room. A job queue of JOB_DEPTH requests lets intake run ahead of the
// output. Write wrap_chars only while the block is idle.
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap
// Top level: byte intake, request queue and character output.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap #(
    parameter int JOB_DEPTH = b64lw_pkg::JOB_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    // wrap_chars register
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    // character output
    output logic       o_empty,
    input  logic       i_pop,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);

    // request path: front -> queue -> back
    logic            q_push;
    logic            q_full;
    b64lw_pkg::t_job q_in_job;
    logic            q_valid;
    logic            q_pop;
    b64lw_pkg::t_job q_out_job;

    // front classifies each byte: hold it, or issue a four/five char request
    b64lw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_job      (q_in_job)
    );

    b64lw_jobq #(
        .DEPTH (JOB_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    // back drains requests into the output register, a char per cycle if free
    b64lw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_out_job),
        .o_q_pop     (q_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule
